### design/firq_pkg.sv
// ----------------------------------------------------------------------------
// firq_pkg
// Shared constants and types for the Q15 direct-form FIR sample filter.
// ----------------------------------------------------------------------------
package firq_pkg;

    localparam int DATA_W     = 16;
    localparam int QSHIFT     = 15;
    localparam int TAPS_DEF   = 58;
    localparam int COEF_IDX_W = 6;

    // Request types on the input channel.
    localparam logic REQ_SAMPLE = 1'b0;
    localparam logic REQ_COEF   = 1'b1;

    // Control handed from the sequencer to the multiply-accumulate unit.
    typedef struct packed {
        logic clear;
        logic en;
        logic last;
    } mac_ctrl_t;

endpackage

### design/firq_mac.sv
// ----------------------------------------------------------------------------
// firq_mac
// Shared multiply-accumulate unit: registered 16x16 product, Q15 scaling,
// and a 16-bit wrapping accumulator.
// ----------------------------------------------------------------------------
module firq_mac
    import firq_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  mac_ctrl_t                ctrl,
    input  logic signed [DATA_W-1:0] op_a,
    input  logic signed [DATA_W-1:0] op_b,
    output logic        [DATA_W-1:0] acc,
    output logic                     done
);

    logic signed [2*DATA_W-1:0] prod_reg;
    logic                       prod_vld_reg;
    logic                       prod_last_reg;
    logic        [DATA_W-1:0]   acc_reg;
    logic        [DATA_W-1:0]   acc_next;
    logic                       done_reg;

    // Each tap adds the product shifted right by the Q15 scale; only the low
    // sixteen bits of the shifted product matter because the sum wraps.
    assign acc_next = acc_reg + prod_reg[QSHIFT +: DATA_W];

    always_ff @(posedge aclk) begin
        prod_reg <= op_a * op_b;
        if (!aresetn) begin
            prod_vld_reg  <= 1'b0;
            prod_last_reg <= 1'b0;
            done_reg      <= 1'b0;
            acc_reg       <= '0;
        end else begin
            prod_vld_reg  <= ctrl.en;
            prod_last_reg <= ctrl.en & ctrl.last;
            done_reg      <= prod_vld_reg & prod_last_reg;
            if (ctrl.clear) begin
                acc_reg <= '0;
            end else if (prod_vld_reg) begin
                acc_reg <= acc_next;
            end
        end
    end

    assign acc  = acc_reg;
    assign done = done_reg;

endmodule

### design/fir_q15_sample_filter.sv
// A sample request runs one multiply-accumulate per tap through a single shared
// multiplier and one read port per memory; a coefficient request gives no result.
// Requests are taken only in idle, so a new one waits until the last result has
// been loaded into the output register, which itself waits for the previous output.
// Reset clears the sequencer, the delay-line fill count and the coefficient
// valid bits; unfilled entries read as zero, so no clearing pass is needed.
// ----------------------------------------------------------------------------
// fir_q15_sample_filter
// Direct-form FIR filter on Q15 samples with a circular delay-line memory,
// a coefficient memory and one shared multiply-accumulate unit.
// ----------------------------------------------------------------------------
module fir_q15_sample_filter
    import firq_pkg::*;
#(
    parameter int TAPS = TAPS_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic                         s_req_type,
    input  logic        [COEF_IDX_W-1:0] s_coef_index,
    input  logic signed [DATA_W-1:0]     s_value,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic signed [DATA_W-1:0]    m_filtered
);

    localparam int AW = (TAPS > 1) ? $clog2(TAPS) : 1;
    localparam int FW = $clog2(TAPS + 1);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_RUN   = 2'd1;
    localparam logic [1:0] S_DRAIN = 2'd2;
    localparam logic [1:0] S_HOLD  = 2'd3;

    logic [1:0]        state_reg, state_next;
    logic [AW-1:0]     tap_reg, tap_next;
    logic [AW-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [AW-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [FW-1:0]     fill_reg, fill_next;
    logic [TAPS-1:0]   coef_vld_reg;
    logic              m_valid_reg, m_valid_next;
    logic [DATA_W-1:0] m_filtered_reg, m_filtered_next;

    logic [DATA_W-1:0] delay_mem [TAPS];
    logic [DATA_W-1:0] coef_mem  [TAPS];
    logic [DATA_W-1:0] delay_rdata_reg;
    logic [DATA_W-1:0] coef_rdata_reg;
    logic              d_ok_reg;
    logic              c_ok_reg;
    logic              rd_vld_reg;
    logic              rd_last_reg;

    logic              accept;
    logic              sample_acc;
    logic              coef_wr;
    logic [AW-1:0]     coef_waddr;
    logic              tap_last;
    logic              out_free;
    mac_ctrl_t         mac_ctrl;
    logic [DATA_W-1:0] mac_acc;
    logic              mac_done;

    assign s_ready    = (state_reg == S_IDLE);
    assign accept     = s_valid & s_ready;
    assign sample_acc = accept & (s_req_type == REQ_SAMPLE);
    assign coef_wr    = accept & (s_req_type == REQ_COEF) & (int'(s_coef_index) < TAPS);
    assign coef_waddr = AW'(s_coef_index);
    assign tap_last   = (tap_reg == AW'(TAPS - 1));
    assign out_free   = ~m_valid_reg | m_ready;

    always_comb begin
        state_next      = state_reg;
        tap_next        = tap_reg;
        rd_ptr_next     = rd_ptr_reg;
        wr_ptr_next     = wr_ptr_reg;
        fill_next       = fill_reg;
        m_valid_next    = m_valid_reg;
        m_filtered_next = m_filtered_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (sample_acc) begin
                    // The new sample lands at the write pointer, which becomes
                    // the newest tap; reads then walk backward from it.
                    rd_ptr_next = wr_ptr_reg;
                    wr_ptr_next = (wr_ptr_reg == AW'(TAPS - 1)) ? '0 : wr_ptr_reg + 1'b1;
                    if (fill_reg != FW'(TAPS)) begin
                        fill_next = fill_reg + 1'b1;
                    end
                    tap_next   = '0;
                    state_next = S_RUN;
                end
            end
            S_RUN: begin
                tap_next    = tap_last ? '0 : tap_reg + 1'b1;
                rd_ptr_next = (rd_ptr_reg == '0) ? AW'(TAPS - 1) : rd_ptr_reg - 1'b1;
                if (tap_last) begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (mac_done) begin
                    if (out_free) begin
                        m_valid_next    = 1'b1;
                        m_filtered_next = mac_acc;
                        state_next      = S_IDLE;
                    end else begin
                        state_next = S_HOLD;
                    end
                end
            end
            S_HOLD: begin
                if (out_free) begin
                    m_valid_next    = 1'b1;
                    m_filtered_next = mac_acc;
                    state_next      = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            tap_reg      <= '0;
            rd_ptr_reg   <= '0;
            wr_ptr_reg   <= '0;
            fill_reg     <= '0;
            coef_vld_reg <= '0;
            m_valid_reg  <= 1'b0;
            rd_vld_reg   <= 1'b0;
            rd_last_reg  <= 1'b0;
        end else begin
            state_reg   <= state_next;
            tap_reg     <= tap_next;
            rd_ptr_reg  <= rd_ptr_next;
            wr_ptr_reg  <= wr_ptr_next;
            fill_reg    <= fill_next;
            m_valid_reg <= m_valid_next;
            rd_vld_reg  <= (state_reg == S_RUN);
            rd_last_reg <= (state_reg == S_RUN) & tap_last;
            if (coef_wr) begin
                coef_vld_reg[coef_waddr] <= 1'b1;
            end
        end
    end

    // Memories and read-side payload registers.
    always_ff @(posedge aclk) begin
        m_filtered_reg  <= m_filtered_next;
        if (sample_acc) begin
            delay_mem[wr_ptr_reg] <= s_value;
        end
        if (coef_wr) begin
            coef_mem[coef_waddr] <= s_value;
        end
        delay_rdata_reg <= delay_mem[rd_ptr_reg];
        coef_rdata_reg  <= coef_mem[tap_reg];
        // Taps older than the number of samples seen since reset read as zero,
        // as do coefficients that were never written.
        d_ok_reg        <= (FW'(tap_reg) < fill_reg);
        c_ok_reg        <= coef_vld_reg[tap_reg];
    end

    assign mac_ctrl.clear = sample_acc;
    assign mac_ctrl.en    = rd_vld_reg;
    assign mac_ctrl.last  = rd_last_reg;

    firq_mac u_mac (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (mac_ctrl),
        .op_a    (d_ok_reg ? signed'(delay_rdata_reg) : '0),
        .op_b    (c_ok_reg ? signed'(coef_rdata_reg) : '0),
        .acc     (mac_acc),
        .done    (mac_done)
    );

    assign m_valid    = m_valid_reg;
    assign m_filtered = signed'(m_filtered_reg);

`ifndef NO_ASSERTIONS
    a_fill_range: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= FW'(TAPS))
        else $error("delay-line fill count exceeds tap count");

    a_ptr_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (int'(rd_ptr_reg) < TAPS) && (int'(wr_ptr_reg) < TAPS))
        else $error("delay-line pointer out of range");

    a_done_in_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        mac_done |-> (state_reg == S_DRAIN))
        else $error("accumulator finished outside the drain phase");

    a_sample_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        sample_acc |=> (state_reg == S_RUN) && (tap_reg == '0))
        else $error("sample request did not start the tap sweep");

    a_no_result_for_coef: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && (s_req_type == REQ_COEF)) |=> (state_reg == S_IDLE))
        else $error("coefficient request left the idle state");
`endif

endmodule

### sim/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the Q15 FIR sample filter. Coefficient and sample
// requests go in over a valid/ready channel, and a behavioral copy of the
// filter predicts every output. Both channels idle at random, and there is
// one long output stall and one full drain of the pipeline.
// ----------------------------------------------------------------------------
module tb;
    import firq_pkg::*;

    localparam int TAPS       = TAPS_DEF;
    localparam int ITEMS      = 1900;
    localparam int CALM_TAIL  = 250;
    localparam int DRAIN_AT   = 900;
    localparam int HOLD_AT    = 450;
    localparam int HOLD_LEN   = 600;
    localparam int IDLE_LIMIT = 5000;
    localparam int SETTLE     = TAPS + 12;
    localparam int MAX_SHOWN  = 10;

    typedef struct {
        logic                        req_type;
        logic [COEF_IDX_W-1:0]       coef_index;
        logic signed [DATA_W-1:0]    value;
    } filt_req_t;

    logic                        aclk = 1'b0;
    logic                        aresetn = 1'b0;
    logic                        s_valid = 1'b0;
    logic                        s_ready;
    logic                        s_req_type = REQ_SAMPLE;
    logic [COEF_IDX_W-1:0]       s_coef_index = '0;
    logic signed [DATA_W-1:0]    s_value = '0;
    logic                        m_valid;
    logic                        m_ready = 1'b0;
    logic signed [DATA_W-1:0]    m_filtered;

    filt_req_t                   req_queue[$];
    logic signed [DATA_W-1:0]    expected_filtered[$];
    logic signed [DATA_W-1:0]    sample_hist[TAPS];
    logic signed [DATA_W-1:0]    coef_mem[TAPS];

    int total_items = 0;
    int directed_items = 0;
    int n_launched = 0;
    int n_accepted = 0;
    int n_results = 0;
    int mismatches = 0;
    int src_gap = 0;
    int sink_gap = 0;
    int hold_left = 0;
    int idle_cycles = 0;
    bit hold_done = 1'b0;
    bit drain_done = 1'b0;

    fir_q15_sample_filter DUT (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_req_type   (s_req_type),
        .s_coef_index (s_coef_index),
        .s_value      (s_value),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_filtered   (m_filtered)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 0;
    end

    // Shifts the sample into the history, forms the wrapped sum of the
    // floored tap products, then ages the history by one position.
    function automatic logic signed [DATA_W-1:0] filter_sample(
        input logic signed [DATA_W-1:0] x);
        logic signed [2*DATA_W-1:0] prod;
        logic [DATA_W-1:0]          acc;
        acc = '0;
        sample_hist[0] = x;
        for (int i = 0; i < TAPS; i++) begin
            prod = sample_hist[i] * coef_mem[i];
            acc = acc + prod[QSHIFT+DATA_W-1:QSHIFT];
        end
        for (int i = TAPS - 1; i > 0; i--)
            sample_hist[i] = sample_hist[i-1];
        return acc;
    endfunction

    // Full-scale and near-zero values show up often enough to hit the wrap cases.
    function automatic logic signed [DATA_W-1:0] rand_q15();
        logic signed [DATA_W-1:0] corner[5];
        corner = '{16'sh8000, 16'sh7fff, -16'sd1, 16'sd0, 16'sd1};
        if ($urandom_range(0, 3) == 0)
            return corner[$urandom_range(0, 4)];
        return DATA_W'($urandom_range(0, 16'hffff));
    endfunction

    task automatic push_coef(input int idx, input logic signed [DATA_W-1:0] v);
        filt_req_t r;
        r.req_type = REQ_COEF;
        r.coef_index = COEF_IDX_W'(idx);
        r.value = v;
        req_queue.push_back(r);
    endtask

    task automatic push_sample(input logic signed [DATA_W-1:0] v);
        filt_req_t r;
        r.req_type = REQ_SAMPLE;
        r.coef_index = COEF_IDX_W'($urandom_range(0, 63));
        r.value = v;
        req_queue.push_back(r);
    endtask

    function automatic bit idling_allowed(input int progress);
        return progress >= directed_items && progress < total_items - CALM_TAIL;
    endfunction

    // Driver: offers the next pending request once the current one is taken.
    always @(posedge aclk) begin
        filt_req_t r;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_ready) begin
            if (!drain_done && n_launched == DRAIN_AT && !s_valid &&
                expected_filtered.size() == 0)
                drain_done = 1'b1;
            if (!drain_done && n_launched == DRAIN_AT) begin
                s_valid <= 1'b0;
            end else if (src_gap > 0) begin
                src_gap--;
                s_valid <= 1'b0;
            end else if (req_queue.size() > 0) begin
                r = req_queue.pop_front();
                s_valid      <= 1'b1;
                s_req_type   <= r.req_type;
                s_coef_index <= r.coef_index;
                s_value      <= r.value;
                n_launched++;
                // Keep pushing while the output is held off so the input backs up.
                if (idling_allowed(n_launched) && hold_left == 0 &&
                    $urandom_range(0, 9) == 0)
                    src_gap = $urandom_range(1, 8);
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Output ready: random short stalls plus one long hold-off.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (!hold_done && n_accepted >= HOLD_AT) begin
            hold_done = 1'b1;
            hold_left = HOLD_LEN;
            m_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else if (sink_gap > 0) begin
            sink_gap--;
            m_ready <= 1'b0;
        end else if (idling_allowed(n_accepted) && $urandom_range(0, 7) == 0) begin
            sink_gap = $urandom_range(1, 8) - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Monitor: predicts on every accepted sample, mirrors in-range coefficient writes, then checks any output.
    always @(posedge aclk) begin
        logic signed [DATA_W-1:0] want;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                n_accepted++;
                if (s_req_type == REQ_SAMPLE)
                    expected_filtered.push_back(filter_sample(s_value));
                else if (s_coef_index < TAPS)
                    coef_mem[s_coef_index] = s_value;
            end
            if (m_valid && m_ready) begin
                n_results++;
                if (expected_filtered.size() == 0) begin
                    mismatches++;
                    if (mismatches <= MAX_SHOWN)
                        $display("unexpected output %0d: got %0d with nothing pending",
                                 n_results, m_filtered);
                end else begin
                    want = expected_filtered.pop_front();
                    if (m_filtered !== want) begin
                        mismatches++;
                        if (mismatches <= MAX_SHOWN)
                            $display("output %0d: filtered expected %0d, got %0d",
                                     n_results, want, m_filtered);
                    end
                end
            end
        end
    end

    // Watchdog on cycles with no transfer on either channel.
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    initial begin
        int idx;
        for (int i = 0; i < TAPS; i++) begin
            sample_hist[i] = '0;
            coef_mem[i] = '0;
        end

        // Directed: reset state, ignored out-of-range writes, the
        // full-scale negative square, floor rounding and sum wrap.
        push_sample(16'sd100);
        push_coef(0, 16'sh8000);
        push_coef(TAPS - 1, 16'sh7fff);
        push_coef(TAPS, 16'sd1234);
        push_coef(63, -16'sd1);
        push_sample(16'sh8000);
        push_coef(1, 16'sh7fff);
        push_sample(16'sh7fff);
        push_coef(2, -16'sd1);
        push_sample(16'sd1);
        push_sample(-16'sd1);
        push_sample(16'sd0);
        push_coef(0, 16'sd1);
        push_sample(16'sd3);
        for (int i = 3; i < 6; i++)
            push_coef(i, 16'sh7fff);
        push_sample(16'sh7fff);
        push_sample(16'sh7fff);
        push_sample(16'sh7fff);
        push_sample(16'sh8000);
        directed_items = req_queue.size();

        // Random: coefficient reloads, partial updates and runs of samples.
        while (req_queue.size() < ITEMS) begin
            if ($urandom_range(0, 4) == 0) begin
                if ($urandom_range(0, 3) == 0) begin
                    for (int i = 0; i < TAPS; i++)
                        push_coef(i, rand_q15());
                end else begin
                    repeat ($urandom_range(1, 12)) begin
                        if ($urandom_range(0, 7) == 0)
                            idx = $urandom_range(TAPS, 63);
                        else
                            idx = $urandom_range(0, TAPS - 1);
                        push_coef(idx, rand_q15());
                    end
                end
            end else begin
                repeat ($urandom_range(1, 40))
                    push_sample(rand_q15());
            end
        end
        total_items = req_queue.size();

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        while (n_accepted < total_items)
            @(posedge aclk);
        while (expected_filtered.size() != 0)
            @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);

        if (mismatches == 0 && expected_filtered.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

### sim.f
design/firq_pkg.sv
design/firq_mac.sv
design/fir_q15_sample_filter.sv
sim/tb.sv
